FILE: design/uttx_pkg.sv
// Shared codes, result record and divider request type for the UART transmit ring.
`default_nettype none
package uttx_pkg;

	localparam logic [2:0] FUNC_HEADER   = 3'd0;
	localparam logic [2:0] FUNC_PAYLOAD  = 3'd1;
	localparam logic [2:0] FUNC_POLL     = 3'd2;
	localparam logic [2:0] FUNC_COMPLETE = 3'd3;
	localparam logic [2:0] FUNC_LINE_ERR = 3'd4;

	localparam logic [1:0] KIND_STATUS   = 2'd0;
	localparam logic [1:0] KIND_CHUNK    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
	localparam logic [1:0] KIND_START_NG = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_RETRY   = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	localparam int BAUD_W      = 24;
	localparam int TIME_W      = 32;
	localparam int LEN_W       = 11;
	localparam int DIV_STEPS   = 32;
	localparam int US_PER_SEC  = 1000000;
	localparam logic [BAUD_W-1:0] BAUD_RESET = 24'd115200;

	typedef struct packed {
		logic [1:0]        kind;
		logic [1:0]        status;
		logic [7:0]        tx_byte;
		logic              last;
		logic [TIME_W-1:0] tout;
		logic [LEN_W-1:0]  free;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] num;
		logic [BAUD_W-1:0] den;
	} div_req_t;

endpackage
`default_nettype wire

FILE: design/uttx_ring.sv
// Byte ring storage with one write port and one registered read port.
`default_nettype none
module uttx_ring #(
	parameter int DEPTH = 1024,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: design/uttx_div.sv
// Iterative restoring divider, one quotient bit per cycle, for the timeout computation.
`default_nettype none
module uttx_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire uttx_pkg::div_req_t           req,
	output logic                              done,
	output logic [uttx_pkg::TIME_W-1:0]       quotient
);
	import uttx_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BAUD_W-1:0] rem_q;
	logic [BAUD_W-1:0] den_q;
	logic [TIME_W-1:0] quo_q;
	logic [BAUD_W:0]   trial;
	logic              fits;

	always_comb begin
		trial = {rem_q, quo_q[TIME_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= !req.start && run_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_STEPS);
				rem_q <= '0;
				den_q <= req.den;
				quo_q <= req.num;
			end else if (run_q) begin
				rem_q <= fits ? BAUD_W'(trial - {1'b0, den_q}) : BAUD_W'(trial);
				quo_q <= {quo_q[TIME_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: design/uart_tx_ring_chunk_dispatch.sv
// Top level: transmit ring with chunked dispatch, transfer watchdog and sequencer.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid/in_ready    func msg_len msg_valid data_byte elapsed_us ...
//  out      output     out_valid/out_ready  kind send_status tx_byte last timeout_elapsed ...
//  cfg      input      cfg_we               cfg_data (baud rate)
//
// Header, payload, complete and line error items are handled on acceptance; a header
// result then waits in the output register until taken. A dispatching poll runs the
// divider for the timeout, then memory read, output load and output hand-off for each
// chunk byte, or a failed-start result if start_ok was low. No item is taken while a
// result is pending. Reset is asynchronous; the ring contents are not cleared.
`default_nettype none
module uart_tx_ring_chunk_dispatch #(
	parameter int RING_DEPTH       = 1024,
	parameter int CHUNK_MAX        = 32,
	parameter int BITS_PER_BYTE    = 10,
	parameter int TIMEOUT_MARGIN   = 2,
	parameter int TIMEOUT_SLACK_US = 1000
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [23:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  func,
	input  wire logic [10:0] msg_len,
	input  wire logic        msg_valid,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] elapsed_us,
	input  wire logic        start_ok,
	input  wire logic        error_dma_affecting,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [1:0]       send_status,
	output logic [7:0]       tx_byte,
	output logic             last,
	output logic [31:0]      timeout_elapsed,
	output logic [10:0]      free_space,
	output logic [31:0]      tx_errors,
	output logic [31:0]      sent_total
);
	import uttx_pkg::*;

	localparam int AW   = $clog2(RING_DEPTH);
	localparam int CW   = $clog2(RING_DEPTH + 1);
	localparam int NW   = $clog2(CHUNK_MAX + 1);
	localparam int XW   = (CW > NW) ? CW : NW;
	localparam int FW   = (CW > LEN_W) ? CW : LEN_W;
	localparam int TW   = CW + 1;
	localparam int LIMW = TIME_W + 8;
	localparam logic [TIME_W-1:0] NUM_SCALE = TIME_W'(BITS_PER_BYTE * US_PER_SEC);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_READ,
		ST_LOAD,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic [BAUD_W-1:0] baud_q;
	logic [AW-1:0]     wr_pos_q;
	logic [CW-1:0]     fill_q;
	logic [LEN_W-1:0]  expect_q;
	logic              busy_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [TIME_W-1:0] limit_q;
	logic [TIME_W-1:0] err_q;
	logic [TIME_W-1:0] sent_q;
	logic [NW-1:0]     chunk_n_q;
	logic [NW-1:0]     chunk_idx_q;
	logic [AW-1:0]     rd_ptr_q;
	logic              start_ok_q;
	logic              div_start_q;
	logic [TIME_W-1:0] div_num_q;
	result_t           res_q;

	logic              accept;
	logic              dispatch;
	logic              ring_wr;
	logic [7:0]        ring_rdata;
	logic [CW-1:0]     free_b;
	logic [FW-1:0]     free_ext;
	logic [NW-1:0]     chunk_n;
	logic [TW-1:0]     tail_sum;
	logic [AW-1:0]     tail;
	logic [TIME_W:0]   acc_sum;
	logic [TIME_W-1:0] acc_sat;
	logic [LIMW-1:0]   lim_full;
	logic [TIME_W-1:0] lim_sat;
	logic              div_done;
	logic [TIME_W-1:0] div_quo;
	div_req_t          div_req;

	function automatic result_t pack_result(input logic [1:0] k, input logic [1:0] st,
			input logic [7:0] b, input logic l, input logic [TIME_W-1:0] t,
			input logic [LEN_W-1:0] f);
		result_t r;
		r.kind    = k;
		r.status  = st;
		r.tx_byte = b;
		r.last    = l;
		r.tout    = t;
		r.free    = f;
		return r;
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign ring_wr  = accept && (func == FUNC_PAYLOAD) && (expect_q != '0)
		&& (fill_q < CW'(RING_DEPTH));
	assign dispatch = accept && (func == FUNC_POLL) && !busy_q && (fill_q != '0);

	always_comb begin
		free_b   = CW'(RING_DEPTH) - fill_q;
		free_ext = FW'(free_b);
		chunk_n  = (XW'(fill_q) < XW'(CHUNK_MAX)) ? NW'(fill_q) : NW'(CHUNK_MAX);
		tail_sum = TW'(wr_pos_q) + TW'(RING_DEPTH) - TW'(fill_q);
		if (tail_sum >= TW'(RING_DEPTH)) begin
			tail_sum = tail_sum - TW'(RING_DEPTH);
		end
		tail     = AW'(tail_sum);
		acc_sum  = {1'b0, elapsed_q} + (TIME_W + 1)'(elapsed_us);
		acc_sat  = acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];
		lim_full = LIMW'(div_quo) * LIMW'(TIMEOUT_MARGIN) + LIMW'(TIMEOUT_SLACK_US);
		lim_sat  = (lim_full[LIMW-1:TIME_W] != '0) ? '1 : lim_full[TIME_W-1:0];
		div_req.start = div_start_q;
		div_req.num   = div_num_q;
		div_req.den   = (baud_q == '0) ? BAUD_W'(1) : baud_q;
	end

	uttx_ring #(
		.DEPTH (RING_DEPTH),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_wr),
		.wr_addr (wr_pos_q),
		.wr_data (data_byte),
		.rd_en   (state_q == ST_READ),
		.rd_addr (rd_ptr_q),
		.rd_data (ring_rdata)
	);

	uttx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			baud_q      <= BAUD_RESET;
			wr_pos_q    <= '0;
			fill_q      <= '0;
			expect_q    <= '0;
			busy_q      <= 1'b0;
			elapsed_q   <= '0;
			limit_q     <= '0;
			err_q       <= '0;
			sent_q      <= '0;
			chunk_n_q   <= '0;
			chunk_idx_q <= '0;
			rd_ptr_q    <= '0;
			start_ok_q  <= 1'b0;
			div_start_q <= 1'b0;
			div_num_q   <= '0;
			res_q       <= '0;
		end else begin
			div_start_q <= dispatch;
			if (cfg_we) begin
				baud_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (func)
							FUNC_HEADER: begin
								state_q <= ST_OUT;
								if (!msg_valid) begin
									res_q <= pack_result(KIND_STATUS, STATUS_INVALID, 8'd0,
										1'b0, '0, '0);
								end else if (FW'(msg_len) > free_ext) begin
									res_q <= pack_result(KIND_STATUS, STATUS_RETRY, 8'd0,
										1'b0, '0, free_ext[LEN_W-1:0]);
								end else begin
									res_q    <= pack_result(KIND_STATUS, STATUS_OK, 8'd0,
										1'b0, '0, '0);
									expect_q <= msg_len;
								end
							end
							FUNC_PAYLOAD: begin
								if (ring_wr) begin
									wr_pos_q <= (wr_pos_q == AW'(RING_DEPTH - 1)) ? '0
										: wr_pos_q + 1'b1;
									fill_q   <= fill_q + 1'b1;
									expect_q <= expect_q - 1'b1;
								end
							end
							FUNC_POLL: begin
								if (busy_q) begin
									elapsed_q <= acc_sat;
									if (acc_sat >= limit_q) begin
										busy_q  <= 1'b0;
										err_q   <= err_q + 1'b1;
										res_q   <= pack_result(KIND_TIMEOUT, STATUS_OK, 8'd0,
											1'b0, acc_sat, '0);
										state_q <= ST_OUT;
									end
								end else if (fill_q != '0) begin
									chunk_n_q   <= chunk_n;
									chunk_idx_q <= '0;
									rd_ptr_q    <= tail;
									fill_q      <= fill_q - CW'(chunk_n);
									elapsed_q   <= '0;
									start_ok_q  <= start_ok;
									div_num_q   <= TIME_W'(TIME_W'(chunk_n) * NUM_SCALE);
									if (start_ok) begin
										sent_q <= sent_q + TIME_W'(chunk_n);
									end else begin
										err_q <= err_q + 1'b1;
									end
									state_q <= ST_DIVIDE;
								end
							end
							FUNC_COMPLETE: begin
								busy_q <= 1'b0;
							end
							FUNC_LINE_ERR: begin
								busy_q <= 1'b0;
								if (error_dma_affecting) begin
									err_q <= err_q + 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIVIDE: begin
					if (div_done) begin
						limit_q <= lim_sat;
						if (start_ok_q) begin
							busy_q  <= 1'b1;
							state_q <= ST_READ;
						end else begin
							res_q   <= pack_result(KIND_START_NG, STATUS_OK, 8'd0, 1'b0,
								'0, '0);
							state_q <= ST_OUT;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					res_q   <= pack_result(KIND_CHUNK, STATUS_OK, ring_rdata,
						(chunk_idx_q + 1'b1) == chunk_n_q, '0, '0);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						if ((res_q.kind == KIND_CHUNK) && !res_q.last) begin
							chunk_idx_q <= chunk_idx_q + 1'b1;
							rd_ptr_q    <= (rd_ptr_q == AW'(RING_DEPTH - 1)) ? '0
								: rd_ptr_q + 1'b1;
							state_q     <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = (state_q == ST_OUT);
	assign kind            = res_q.kind;
	assign send_status     = res_q.status;
	assign tx_byte         = res_q.tx_byte;
	assign last            = res_q.last;
	assign timeout_elapsed = res_q.tout;
	assign free_space      = res_q.free;
	assign tx_errors       = err_q;
	assign sent_total      = sent_q;

`ifndef SYNTHESIS
	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("Input taken while a result is pending.");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(RING_DEPTH))
		else $error("Ring fill count exceeds depth.");
	a_last_only_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_q.last |-> res_q.kind == KIND_CHUNK)
		else $error("Last flag on a result that is not a chunk byte.");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVIDE)
		else $error("Divider finished outside the divide step.");
	a_chunk_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> chunk_idx_q < chunk_n_q)
		else $error("Chunk read index beyond chunk length.");
`endif

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Testbench for the UART transmit ring: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module testbench;
	import uttx_pkg::*;

	localparam int RING_DEPTH = 1024;
	localparam int CHUNK_MAX = 32;
	localparam int BITS_PER_BYTE = 10;
	localparam int TIMEOUT_MARGIN = 2;
	localparam int TIMEOUT_SLACK_US = 1000;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int CFG_SETTLE = 64;
	localparam int END_SETTLE = 150;
	localparam int ERROR_PRINT_MAX = 200;
	localparam logic [2:0] FUNC_UNUSED_FIRST = FUNC_LINE_ERR + 3'd1;
	localparam logic [2:0] FUNC_UNUSED_LAST = 3'd7;

	typedef struct packed {
		logic [2:0]  func;
		logic [10:0] msg_len;
		logic        msg_valid;
		logic [7:0]  data_byte;
		logic [15:0] elapsed_us;
		logic        start_ok;
		logic        error_dma_affecting;
	} tx_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  send_status;
		logic [7:0]  tx_byte;
		logic        last;
		logic [31:0] timeout_elapsed;
		logic [10:0] free_space;
		logic [31:0] tx_errors;
		logic [31:0] sent_total;
	} uart_out_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [23:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  func;
	logic [10:0] msg_len;
	logic        msg_valid;
	logic [7:0]  data_byte;
	logic [15:0] elapsed_us;
	logic        start_ok;
	logic        error_dma_affecting;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [1:0]  send_status;
	logic [7:0]  tx_byte;
	logic        last;
	logic [31:0] timeout_elapsed;
	logic [10:0] free_space;
	logic [31:0] tx_errors;
	logic [31:0] sent_total;

	// Predicted state of the ring, the watchdog and the counters.
	logic [7:0]  ring_img [RING_DEPTH];
	int unsigned wr_ptr = 0;
	int unsigned fill_lvl = 0;
	int unsigned msg_left = 0;
	bit          xfer_busy = 1'b0;
	logic [31:0] busy_us = '0;
	logic [31:0] limit_us = '0;
	logic [31:0] err_cnt = '0;
	logic [31:0] sent_cnt = '0;
	logic [23:0] baud_reg = BAUD_RESET;

	uart_out_t   uart_out_q [$];
	int          fail_cnt = 0;
	int          useful_items = 0;
	int          cycle_cnt = 0;
	int          hold_req = 0;
	bit          calm = 1'b0;

	uart_tx_ring_chunk_dispatch dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.msg_len(msg_len),
		.msg_valid(msg_valid),
		.data_byte(data_byte),
		.elapsed_us(elapsed_us),
		.start_ok(start_ok),
		.error_dma_affecting(error_dma_affecting),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.send_status(send_status),
		.tx_byte(tx_byte),
		.last(last),
		.timeout_elapsed(timeout_elapsed),
		.free_space(free_space),
		.tx_errors(tx_errors),
		.sent_total(sent_total)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] watchdog_limit(input int unsigned n);
		longint unsigned den;
		longint unsigned line_us;
		longint unsigned lim;
		den = (baud_reg == '0) ? 64'd1 : 64'(baud_reg);
		line_us = 64'(n) * BITS_PER_BYTE * US_PER_SEC;
		line_us = line_us / den;
		if (line_us > 64'hFFFF_FFFF)
			line_us = 64'hFFFF_FFFF;
		lim = line_us * TIMEOUT_MARGIN + TIMEOUT_SLACK_US;
		return (lim > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(lim);
	endfunction

	function automatic void await_out(input logic [1:0] k, input logic [1:0] st,
			input logic [7:0] b, input logic l, input logic [31:0] t, input logic [10:0] f);
		uart_out_t r;
		r.kind = k;
		r.send_status = st;
		r.tx_byte = b;
		r.last = l;
		r.timeout_elapsed = t;
		r.free_space = f;
		r.tx_errors = err_cnt;
		r.sent_total = sent_cnt;
		uart_out_q.push_back(r);
	endfunction

	// Applies one accepted item to the predicted state and queues the results it causes.
	// Returns 0 for a payload byte that is not stored and for an unused function code.
	function automatic bit ring_apply(input tx_item_t it);
		int unsigned freeb;
		int unsigned n;
		int unsigned tail;
		int unsigned i;
		logic [32:0] sum;
		bit effect;
		effect = 1'b1;
		case (it.func)
			FUNC_HEADER: begin
				freeb = RING_DEPTH - fill_lvl;
				if (!it.msg_valid) begin
					await_out(KIND_STATUS, STATUS_INVALID, '0, 1'b0, '0, '0);
				end else if (it.msg_len > freeb) begin
					await_out(KIND_STATUS, STATUS_RETRY, '0, 1'b0, '0, 11'(freeb));
				end else begin
					msg_left = it.msg_len;
					await_out(KIND_STATUS, STATUS_OK, '0, 1'b0, '0, '0);
				end
			end
			FUNC_PAYLOAD: begin
				if (msg_left > 0 && fill_lvl < RING_DEPTH) begin
					ring_img[wr_ptr] = it.data_byte;
					wr_ptr = (wr_ptr + 1) % RING_DEPTH;
					fill_lvl++;
					msg_left--;
				end else begin
					effect = 1'b0;
				end
			end
			FUNC_POLL: begin
				if (xfer_busy) begin
					sum = {1'b0, busy_us} + it.elapsed_us;
					busy_us = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if (busy_us >= limit_us) begin
						xfer_busy = 1'b0;
						err_cnt++;
						await_out(KIND_TIMEOUT, '0, '0, 1'b0, busy_us, '0);
					end
				end else if (fill_lvl > 0) begin
					n = (fill_lvl < CHUNK_MAX) ? fill_lvl : CHUNK_MAX;
					tail = (wr_ptr + RING_DEPTH - fill_lvl) % RING_DEPTH;
					fill_lvl -= n;
					limit_us = watchdog_limit(n);
					busy_us = '0;
					if (!it.start_ok) begin
						err_cnt++;
						await_out(KIND_START_NG, '0, '0, 1'b0, '0, '0);
					end else begin
						xfer_busy = 1'b1;
						sent_cnt += n;
						for (i = 0; i < n; i++)
							await_out(KIND_CHUNK, '0, ring_img[(tail + i) % RING_DEPTH],
								(i + 1 == n), '0, '0);
					end
				end
			end
			FUNC_COMPLETE: begin
				xfer_busy = 1'b0;
			end
			FUNC_LINE_ERR: begin
				xfer_busy = 1'b0;
				if (it.error_dma_affecting)
					err_cnt++;
			end
			default: begin
				effect = 1'b0;
			end
		endcase
		return effect;
	endfunction

	function automatic tx_item_t rand_item(input logic [2:0] f);
		tx_item_t it;
		it.func = f;
		it.msg_len = 11'($urandom_range(0, 2047));
		it.msg_valid = 1'($urandom_range(0, 1));
		it.data_byte = 8'($urandom_range(0, 255));
		it.elapsed_us = 16'($urandom_range(0, 65535));
		it.start_ok = 1'($urandom_range(0, 1));
		it.error_dma_affecting = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			if (fail_cnt < ERROR_PRINT_MAX)
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk) begin
		uart_out_t want;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			if (uart_out_q.size() == 0) begin
				if (fail_cnt < ERROR_PRINT_MAX)
					$error("result with no item pending: kind %0d", kind);
				fail_cnt++;
			end else begin
				want = uart_out_q.pop_front();
				check_field("kind", want.kind, kind);
				check_field("send_status", want.send_status, send_status);
				check_field("tx_byte", want.tx_byte, tx_byte);
				check_field("last", want.last, last);
				check_field("timeout_elapsed", want.timeout_elapsed, timeout_elapsed);
				check_field("free_space", want.free_space, free_space);
				check_field("tx_errors", want.tx_errors, tx_errors);
				check_field("sent_total", want.sent_total, sent_total);
			end
		end
	end

	// Result side: random stall bursts, or one long hold-off when requested.
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input tx_item_t it);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 17);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= it.func;
		msg_len <= it.msg_len;
		msg_valid <= it.msg_valid;
		data_byte <= it.data_byte;
		elapsed_us <= it.elapsed_us;
		start_ok <= it.start_ok;
		error_dma_affecting <= it.error_dma_affecting;
		do @(posedge clk); while (in_ready !== 1'b1);
		if (ring_apply(it))
			useful_items++;
	endtask

	task automatic send_header(input logic valid, input logic [10:0] len);
		tx_item_t it;
		it = rand_item(FUNC_HEADER);
		it.msg_valid = valid;
		it.msg_len = len;
		send_item(it);
	endtask

	task automatic send_byte(input logic [7:0] b);
		tx_item_t it;
		it = rand_item(FUNC_PAYLOAD);
		it.data_byte = b;
		send_item(it);
	endtask

	task automatic send_poll(input logic [15:0] us, input logic ok);
		tx_item_t it;
		it = rand_item(FUNC_POLL);
		it.elapsed_us = us;
		it.start_ok = ok;
		send_item(it);
	endtask

	task automatic send_line_error(input logic dma);
		tx_item_t it;
		it = rand_item(FUNC_LINE_ERR);
		it.error_dma_affecting = dma;
		send_item(it);
	endtask

	task automatic send_message(input int len);
		send_header(1'b1, 11'(len));
		repeat (len) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic empty_ring();
		send_item(rand_item(FUNC_COMPLETE));
		while (fill_lvl > 0) begin
			send_poll(16'($urandom_range(0, 65535)), 1'b1);
			send_item(rand_item(FUNC_COMPLETE));
		end
	endtask

	// Lowers valid and waits until every predicted result has been taken.
	task automatic settle_out(input int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (uart_out_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_baud(input logic [23:0] b);
		settle_out(CFG_SETTLE);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= b;
		@(negedge clk);
		cfg_we <= 1'b0;
		baud_reg = b;
	endtask

	task automatic test_header_status();
		send_header(1'b0, 11'd2047);
		send_header(1'b1, 11'd2047);
		send_header(1'b1, 11'd1024);
		// The earlier message is cut short by a new header.
		send_header(1'b1, 11'd4);
	endtask

	task automatic test_payload_and_noise();
		tx_item_t it;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		send_byte(8'hA5);
		send_byte(8'h3C);
		for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++) begin
			it = '1;
			it.func = 3'(f);
			send_item(it);
		end
	endtask

	task automatic test_failed_start();
		send_poll(16'd0, 1'b0);
		send_poll(16'hFFFF, 1'b1);
	endtask

	task automatic test_watchdog_expiry();
		send_message(2);
		send_poll(16'd0, 1'b1);
		send_poll(16'(limit_us - 1), 1'b1);
		send_poll(16'd1, 1'b1);
	endtask

	task automatic test_complete_and_line_error();
		send_message(1);
		send_poll(16'd0, 1'b1);
		send_item(rand_item(FUNC_COMPLETE));
		send_poll(16'hFFFF, 1'b1);
		send_message(1);
		send_poll(16'd0, 1'b1);
		send_line_error(1'b1);
		send_line_error(1'b0);
	endtask

	// A header one byte above the free space is refused, one that fits exactly is taken.
	task automatic test_ring_retry();
		empty_ring();
		send_message(40);
		send_header(1'b1, 11'(RING_DEPTH - fill_lvl + 1));
		send_header(1'b1, 11'(RING_DEPTH - fill_lvl));
		send_header(1'b1, 11'd0);
		empty_ring();
	endtask

	task automatic test_backpressure();
		hold_req = 400;
		send_message(CHUNK_MAX);
		send_poll(16'd0, 1'b1);
		repeat (6) send_header(1'b1, 11'($urandom_range(0, 8)));
		settle_out(0);
		send_item(rand_item(FUNC_COMPLETE));
	endtask

	task automatic test_baud_extremes();
		logic [23:0] rates [6];
		int len;
		int polls;
		rates = '{24'd0, 24'd1, 24'd12000000, 24'hFFFFFF, 24'd9600, BAUD_RESET};
		foreach (rates[k]) begin
			empty_ring();
			set_baud(rates[k]);
			len = (rates[k] < 24'd2) ? 1 : $urandom_range(1, 8);
			send_message(len);
			send_poll(16'd0, 1'b1);
			polls = 0;
			while (xfer_busy && polls < 4) begin
				send_poll(16'($urandom_range(32768, 65535)), 1'b1);
				polls++;
			end
		end
	endtask

	task automatic test_random_traffic(input int quota);
		tx_item_t it;
		int goal;
		int len;
		int r;
		goal = useful_items + quota;
		while (useful_items < goal) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 120) : $urandom_range(0, 16);
				if ($urandom_range(0, 19) == 0)
					len = $urandom_range(RING_DEPTH + 1, 2047);
				send_header(1'b1, 11'(len));
				len = msg_left;
				if ($urandom_range(0, 7) == 0)
					len = $urandom_range(0, len);
				repeat (len) send_byte(8'($urandom_range(0, 255)));
			end else if (r < 78) begin
				it = rand_item(FUNC_POLL);
				if ($urandom_range(0, 1) == 0)
					it.elapsed_us = 16'($urandom_range(0, 1500));
				it.start_ok = ($urandom_range(0, 7) != 0);
				send_item(it);
			end else if (r < 86) begin
				send_item(rand_item(FUNC_COMPLETE));
			end else if (r < 91) begin
				send_item(rand_item(FUNC_LINE_ERR));
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						it = rand_item(FUNC_HEADER);
						it.msg_valid = 1'b0;
					end
					1: it = rand_item(FUNC_PAYLOAD);
					default: it = rand_item(3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)));
				endcase
				send_item(it);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = '0;
		msg_len = '0;
		msg_valid = 1'b0;
		data_byte = '0;
		elapsed_us = '0;
		start_ok = 1'b0;
		error_dma_affecting = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_header_status();
		test_payload_and_noise();
		test_failed_start();
		test_watchdog_expiry();
		test_complete_and_line_error();
		test_ring_retry();
		test_backpressure();
		test_baud_extremes();

		test_random_traffic(40);
		set_baud(24'($urandom_range(300, 1000000)));
		test_random_traffic(40);
		set_baud(24'd12000000);
		test_random_traffic(40);
		calm = 1'b1;
		set_baud(24'd57600);
		test_random_traffic(40);

		settle_out(END_SETTLE);
		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/uttx_pkg.sv
design/uttx_ring.sv
design/uttx_div.sv
design/uart_tx_ring_chunk_dispatch.sv
verif/testbench.sv
